[design/mspp_pkg.sv]
// Shared types and constants for the motor speed packet parser.
// No dependencies; imported by the front, queue, back and top-level modules.
package mspp_pkg;

   localparam int unsigned PKT_LEN = 10;

   localparam logic [7:0] CH_START = 8'h24;   // '$'
   localparam logic [7:0] CH_LEFT  = 8'h4C;   // 'L'
   localparam logic [7:0] CH_RIGHT = 8'h52;   // 'R'
   localparam logic [7:0] CH_MINUS = 8'h2D;   // '-'
   localparam logic [7:0] CH_PLUS  = 8'h2B;   // '+'
   localparam logic signed [8:0] CH_ZERO = 9'sd48;

   localparam logic signed [15:0] SPEED_MAX = 16'sd255;
   localparam logic signed [15:0] SPEED_MIN = -16'sd255;

   typedef enum logic [1:0] {
      SIGN_ZERO = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd2
   } sign_type;

   // digits[0] is hundreds, digits[2] is units
   typedef struct packed {
      sign_type          sign;
      logic [2:0][7:0]   digits;
   } speed_field_type;

   typedef struct packed {
      speed_field_type left;
      speed_field_type right;
   } packet_type;

   // queue status seen by the front and back parts
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic sign_type decode_sign(logic [7:0] b);
      sign_type s;
      unique case (b)
         CH_MINUS: s = SIGN_NEG;
         CH_PLUS:  s = SIGN_POS;
         default:  s = SIGN_ZERO;
      endcase
      return s;
   endfunction

endpackage

[design/mspp_front.sv]
// Front part: byte capture, framing and marker check.
// Depends on mspp_pkg; pushes checked packets into mspp_queue.
module mspp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_rx_byte,
   input  mspp_pkg::queue_status_type   q_status,
   output logic                         push_valid,
   output mspp_pkg::packet_type         push_packet
);
   import mspp_pkg::*;

   localparam int unsigned HIST_LEN = PKT_LEN - 1;
   localparam logic [3:0]  LAST_IDX = 4'(PKT_LEN - 1);

   logic             capturing_ff, capturing_in;
   logic [3:0]       count_ff, count_in;
   logic [7:0]       hist_ff [HIST_LEN];
   logic             accept;
   logic             last_byte;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign last_byte = capturing_ff && (count_ff == LAST_IDX);

   always_comb begin
      capturing_in = capturing_ff;
      count_in     = count_ff;
      if (accept) begin
         if (!capturing_ff) begin
            if (req_rx_byte == CH_START) begin
               capturing_in = 1'b1;
               count_in     = '0;
            end
         end else if (last_byte) begin
            capturing_in = 1'b0;
            count_in     = '0;
         end else begin
            count_in = count_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         capturing_ff <= capturing_in;
         count_ff     <= count_in;
      end
   end

   // shift line: after nine data words hist_ff[k] holds packet word k
   always_ff @(posedge clock) begin
      if (accept && capturing_ff) begin
         for (int k = 0; k < HIST_LEN - 1; k++) begin
            hist_ff[k] <= hist_ff[k + 1];
         end
         hist_ff[HIST_LEN - 1] <= req_rx_byte;
      end
   end

   // the tenth word is still on the input when the packet closes
   always_comb begin
      push_packet.left.sign       = decode_sign(hist_ff[1]);
      push_packet.left.digits[0]  = hist_ff[2];
      push_packet.left.digits[1]  = hist_ff[3];
      push_packet.left.digits[2]  = hist_ff[4];
      push_packet.right.sign      = decode_sign(hist_ff[6]);
      push_packet.right.digits[0] = hist_ff[7];
      push_packet.right.digits[1] = hist_ff[8];
      push_packet.right.digits[2] = req_rx_byte;
   end

   assign push_valid = accept && last_byte
                       && (hist_ff[0] == CH_LEFT) && (hist_ff[5] == CH_RIGHT);

endmodule

[design/mspp_queue.sv]
// Two-entry packet queue between the front and back parts.
// Depends on mspp_pkg for the packet and status types.
module mspp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  mspp_pkg::packet_type         push_packet,
   input  logic                         pop,
   output mspp_pkg::packet_type         head_packet,
   output mspp_pkg::queue_status_type   q_status
);
   import mspp_pkg::*;

   localparam int unsigned DEPTH = 2;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   packet_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_packet    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_packet;
      end
   end

endmodule

[design/mspp_back.sv]
// Back part: digit arithmetic, sign, saturation and the result register.
// Depends on mspp_pkg; pops packets from mspp_queue.
module mspp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  mspp_pkg::packet_type         head_packet,
   input  mspp_pkg::queue_status_type   q_status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [8:0]            rsp_left_speed,
   output logic signed [8:0]            rsp_right_speed
);
   import mspp_pkg::*;

   logic                valid_ff, valid_in;
   logic signed [8:0]   left_ff, left_in;
   logic signed [8:0]   right_ff, right_in;

   function automatic logic signed [8:0] speed_of(speed_field_type f);
      logic signed [8:0]  d0, d1, d2;
      logic signed [15:0] mag, v;
      d0  = $signed({f.digits[0][7], f.digits[0]}) - CH_ZERO;
      d1  = $signed({f.digits[1][7], f.digits[1]}) - CH_ZERO;
      d2  = $signed({f.digits[2][7], f.digits[2]}) - CH_ZERO;
      // constant multiplies: shift-and-add after synthesis
      mag = 16'(d0) * 16'sd100 + 16'(d1) * 16'sd10 + 16'(d2);
      unique case (f.sign)
         SIGN_NEG: v = -mag;
         SIGN_POS: v = mag;
         default:  v = '0;
      endcase
      if (v > SPEED_MAX) begin
         v = SPEED_MAX;
      end else if (v < SPEED_MIN) begin
         v = SPEED_MIN;
      end
      return v[8:0];
   endfunction

   assign pop = !q_status.empty && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (pop) begin
         valid_in = 1'b1;
         left_in  = speed_of(head_packet.left);
         right_in = speed_of(head_packet.right);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_right_speed = right_ff;

endmodule

[design/motor_speed_packet_parser_unit.sv]
// Top level of the motor speed packet parser: front, queue and back.
// Depends on mspp_pkg, mspp_front, mspp_queue and mspp_back.
// Throughput: one input word per cycle, held off only while the packet queue is full.
// The result of the tenth packet word passes the queue, then the result register, before the
// result port can take it; it waits longer if the result port stalls.
// Reset: synchronous, active high; clears capture state, queue pointers and result valid.
module motor_speed_packet_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [8:0] rsp_left_speed,
   output logic signed [8:0] rsp_right_speed
);
   import mspp_pkg::*;

   logic               push_valid;
   packet_type         push_packet;
   packet_type         head_packet;
   logic               pop;
   queue_status_type   q_status;

   mspp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_packet (push_packet)
   );

   mspp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_packet (push_packet),
      .pop         (pop),
      .head_packet (head_packet),
      .q_status    (q_status)
   );

   mspp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_packet     (head_packet),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed)
   );

endmodule

[design/mspp_checker.sv]
// Port-level checks for motor_speed_packet_parser_unit, attached by bind.
// No package dependency; sees the top-level ports only.
module mspp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [8:0] rsp_left_speed,
   input logic signed [8:0] rsp_right_speed
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_speed)
                                 && $stable(rsp_right_speed))
      else $error("result word changed while stalled");

   // saturation keeps -256 off both speeds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_speed != -9'sd256) && (rsp_right_speed != -9'sd256))
      else $error("speed outside saturation range");

   // reset leaves no result pending
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a fresh result follows an accepted input word
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a closing input word");

endmodule

bind motor_speed_packet_parser_unit mspp_checker u_mspp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_left_speed  (rsp_left_speed),
   .rsp_right_speed (rsp_right_speed)
);
